@@ hdl/rsi_pkg.sv @@
// Shared widths, codes and request types for the ray and segment intersection block.
package rsi_pkg;

  // Coordinate width of every Q16.16 value taken from the ports and registers
  localparam int CW = 32;
  // Width of the result coordinate ports
  localparam int OW = 32;
  // Fraction bits of the fixed point format
  localparam int FRAC = 16;

  // Differences of two coordinates
  localparam int DW = CW + 1;
  // Products of two differences
  localparam int PW = 2 * DW;
  // Cross products and dot product, with headroom for negation
  localparam int WW = PW + 2;
  // Magnitude of a cross product
  localparam int MW = WW - 1;
  // Remainder of the distance and position dividers
  localparam int RW = WW + 1;

  // Distance quotient bits and the shift that sets its saturation bound
  localparam int TQW = 31;
  localparam int SH = TQW - FRAC;
  // Segment position quotient bits (0 to 1.0 inclusive)
  localparam int SQW = FRAC + 1;

  // Distance times direction, and position times normal difference
  localparam int TPW = TQW + 1 + CW;
  localparam int IPW = SQW + 1 + DW;
  // Hit point sum before saturation
  localparam int HW = TPW - FRAC + 1;

  // Sum of squared normal components and its root
  localparam int SSW = 2 * CW;
  // Normal divider: quotient bits and remainder width
  localparam int NQW = FRAC + 1;
  localparam int RNW = CW + 2;

  // Configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_SEG_START     = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_SEG_END       = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_NORMAL_START  = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_NORMAL_END    = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_SEG_TYPE      = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_IGNORE_SOURCE = 3'd5;

  // Surface kinds
  localparam logic [1:0] KIND_SOURCE = 2'd0;
  localparam logic [1:0] KIND_TARGET = 2'd1;
  localparam logic [1:0] KIND_OTHER  = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Result fields that are settled before the normal is normalized
  typedef struct packed {
    logic                  hit;
    logic [TQW-1:0]        distance;
    logic signed [OW-1:0]  hit_x;
    logic signed [OW-1:0]  hit_y;
    logic [1:0]            kind;
  } side_t;

  // Request into the normalizing unit
  typedef struct packed {
    logic                  valid;
    side_t                 side;
    logic signed [CW-1:0]  nx;
    logic signed [CW-1:0]  ny;
  } norm_req_t;

  // Finished result out of the normalizing unit
  typedef struct packed {
    logic                  valid;
    side_t                 side;
    logic signed [OW-1:0]  normal_x;
    logic signed [OW-1:0]  normal_y;
  } norm_rsp_t;

endpackage

@@ hdl/rsi_norm.sv @@
// Normalizing unit: squares, pipelined square root and per-component division of the normal.
module rsi_norm import rsi_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  norm_req_t req_i,
  output norm_rsp_t rsp_o
);

  typedef struct packed {
    side_t          side;
    logic           negx;
    logic           negy;
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
  } abs_t;

  typedef struct packed {
    side_t          side;
    logic           negx;
    logic           negy;
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
    logic [SSW-1:0] sqx;
    logic [SSW-1:0] sqy;
  } sq_t;

  typedef struct packed {
    side_t          side;
    logic           negx;
    logic           negy;
    logic [CW-1:0]  ax;
    logic [CW-1:0]  ay;
    logic [SSW-1:0] v;
    logic [SSW-1:0] r;
  } root_t;

  typedef struct packed {
    side_t          side;
    logic           negx;
    logic           negy;
    logic           zl;
    logic [CW-1:0]  len;
    logic [RNW-1:0] rx;
    logic [RNW-1:0] ry;
    logic [NQW-1:0] xlow;
    logic [NQW-1:0] ylow;
    logic [NQW-1:0] qx;
    logic [NQW-1:0] qy;
  } ndiv_t;

  logic      a_v_q;
  abs_t      a_q;
  logic      m_v_q;
  sq_t       m_q;
  logic      sr_v_q [CW+1];
  root_t     sr_q   [CW+1];
  root_t     sr_d   [CW+1];
  logic      nd_v_q [NQW+1];
  ndiv_t     nd_q   [NQW+1];
  ndiv_t     nd_d   [NQW+1];
  norm_rsp_t rsp_q;
  norm_rsp_t rsp_d;
  ndiv_t     nd_last;
  logic signed [OW-1:0] ux;
  logic signed [OW-1:0] uy;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      m_v_q <= 1'b0;
      for (int k = 0; k <= CW; k++) sr_v_q[k] <= 1'b0;
      for (int k = 0; k <= NQW; k++) nd_v_q[k] <= 1'b0;
      rsp_q <= '0;
    end else if (en_i) begin
      a_v_q <= req_i.valid;
      m_v_q <= a_v_q;
      sr_v_q[0] <= m_v_q;
      for (int k = 0; k < CW; k++) sr_v_q[k+1] <= sr_v_q[k];
      nd_v_q[0] <= sr_v_q[CW];
      for (int k = 0; k < NQW; k++) nd_v_q[k+1] <= nd_v_q[k];
      rsp_q <= rsp_d;
    end
  end

  // Split each component into sign and magnitude
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q.side <= req_i.side;
      a_q.negx <= req_i.nx[CW-1];
      a_q.negy <= req_i.ny[CW-1];
      a_q.ax   <= req_i.nx[CW-1] ? CW'(-req_i.nx) : CW'(req_i.nx);
      a_q.ay   <= req_i.ny[CW-1] ? CW'(-req_i.ny) : CW'(req_i.ny);
    end
  end

  // Square the magnitudes
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q.side <= a_q.side;
      m_q.negx <= a_q.negx;
      m_q.negy <= a_q.negy;
      m_q.ax   <= a_q.ax;
      m_q.ay   <= a_q.ay;
      m_q.sqx  <= SSW'(a_q.ax) * SSW'(a_q.ax);
      m_q.sqy  <= SSW'(a_q.ay) * SSW'(a_q.ay);
    end
  end

  // Sum the squares into the first root stage
  always_comb begin
    sr_d[0].side = m_q.side;
    sr_d[0].negx = m_q.negx;
    sr_d[0].negy = m_q.negy;
    sr_d[0].ax   = m_q.ax;
    sr_d[0].ay   = m_q.ay;
    sr_d[0].v    = m_q.sqx + m_q.sqy;
    sr_d[0].r    = '0;
  end

  // Square root, one result bit per stage
  for (genvar j = 0; j < CW; j++) begin : g_root
    localparam logic [SSW-1:0] BJ = SSW'(1) << (SSW - 2 - 2 * j);
    logic [SSW-1:0] trial;
    always_comb begin
      sr_d[j+1] = sr_q[j];
      trial = sr_q[j].r + BJ;
      if (sr_q[j].v >= trial) begin
        sr_d[j+1].v = sr_q[j].v - trial;
        sr_d[j+1].r = (sr_q[j].r >> 1) + BJ;
      end else begin
        sr_d[j+1].r = sr_q[j].r >> 1;
      end
    end
  end

  // Load the normal divider with the root as divisor
  always_comb begin
    nd_d[0].side = sr_q[CW].side;
    nd_d[0].negx = sr_q[CW].negx;
    nd_d[0].negy = sr_q[CW].negy;
    nd_d[0].len  = sr_q[CW].r[CW-1:0];
    nd_d[0].zl   = (sr_q[CW].r == '0);
    nd_d[0].rx   = RNW'(sr_q[CW].ax[CW-1:1]);
    nd_d[0].ry   = RNW'(sr_q[CW].ay[CW-1:1]);
    nd_d[0].xlow = {sr_q[CW].ax[0], {FRAC{1'b0}}};
    nd_d[0].ylow = {sr_q[CW].ay[0], {FRAC{1'b0}}};
    nd_d[0].qx   = '0;
    nd_d[0].qy   = '0;
  end

  // Divide both magnitudes by the length, one quotient bit per stage
  for (genvar k = 0; k < NQW; k++) begin : g_ndiv
    logic [RNW-1:0] rx2;
    logic [RNW-1:0] ry2;
    always_comb begin
      nd_d[k+1] = nd_q[k];
      rx2 = {nd_q[k].rx[RNW-2:0], nd_q[k].xlow[NQW-1]};
      ry2 = {nd_q[k].ry[RNW-2:0], nd_q[k].ylow[NQW-1]};
      nd_d[k+1].xlow = nd_q[k].xlow << 1;
      nd_d[k+1].ylow = nd_q[k].ylow << 1;
      if (rx2 >= RNW'(nd_q[k].len)) begin
        nd_d[k+1].rx = rx2 - RNW'(nd_q[k].len);
        nd_d[k+1].qx = {nd_q[k].qx[NQW-2:0], 1'b1};
      end else begin
        nd_d[k+1].rx = rx2;
        nd_d[k+1].qx = {nd_q[k].qx[NQW-2:0], 1'b0};
      end
      if (ry2 >= RNW'(nd_q[k].len)) begin
        nd_d[k+1].ry = ry2 - RNW'(nd_q[k].len);
        nd_d[k+1].qy = {nd_q[k].qy[NQW-2:0], 1'b1};
      end else begin
        nd_d[k+1].ry = ry2;
        nd_d[k+1].qy = {nd_q[k].qy[NQW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k <= CW; k++) sr_q[k] <= sr_d[k];
      for (int k = 0; k <= NQW; k++) nd_q[k] <= nd_d[k];
    end
  end

  // Restore the signs; drop the normal on a miss or a zero length
  assign nd_last = nd_q[NQW];
  assign ux = OW'($signed({1'b0, nd_last.qx}));
  assign uy = OW'($signed({1'b0, nd_last.qy}));

  always_comb begin
    rsp_d = '0;
    rsp_d.valid = nd_v_q[NQW];
    rsp_d.side = nd_last.side;
    if (nd_last.side.hit && !nd_last.zl) begin
      rsp_d.normal_x = nd_last.negx ? -ux : ux;
      rsp_d.normal_y = nd_last.negy ? -uy : uy;
    end
  end

  assign rsp_o = rsp_q;

endmodule

@@ hdl/ray_segment_intersect_2d.sv @@
// Top level: tests a stream of 2D rays against one configured segment.
//
// Usage:
//   Write the segment end points, end point normals, surface kind and the
//   source ignore flag through the cfg channel (index plus 64-bit data)
//   while no ray is in flight; cfg_ready_o is always high.
//   Rays enter on the in channel (origin and direction, Q16.16), one per
//   cycle while in_ready_o is high. Each ray gives exactly one result on
//   the out channel: the hit flag, distance, hit point, unit normal and
//   surface kind, all zero on a miss.
//   The pipeline depth is set by the 31-stage distance divider, the
//   32-stage square root and the 17-stage normal divider, each retiring
//   one bit a stage. Throughput is one ray per cycle while in_ready_o
//   is high.
//   When the receiver stalls, the result waiting in the output register
//   holds and one more result parks in a skid register; the pipeline then
//   freezes and in_ready_o drops until the skid register empties.
//   Reset clears all valid bits and sets the registers to their defaults
//   (zero points and normals, kind other surface, sources not ignored).
module ray_segment_intersect_2d import rsi_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IW-1:0]       cfg_index_i,
  input  logic [63:0]             cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic signed [31:0]      origin_x_i,
  input  logic signed [31:0]      origin_y_i,
  input  logic signed [31:0]      dir_x_i,
  input  logic signed [31:0]      dir_y_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic                    hit_o,
  output logic [TQW-1:0]          distance_o,
  output logic signed [OW-1:0]    hit_x_o,
  output logic signed [OW-1:0]    hit_y_o,
  output logic signed [OW-1:0]    normal_x_o,
  output logic signed [OW-1:0]    normal_y_o,
  output logic [1:0]              hit_kind_o
);

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [DW-1:0] wx;
    logic signed [DW-1:0] wy;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [PW-1:0] pa;
    logic signed [PW-1:0] pb;
    logic signed [PW-1:0] pc;
    logic signed [PW-1:0] pd;
    logic signed [PW-1:0] pe;
    logic signed [PW-1:0] pf;
    logic signed [PW-1:0] pg;
    logic signed [PW-1:0] ph;
  } prod_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 miss;
    logic signed [WW-1:0] den;
    logic signed [WW-1:0] sn;
    logic signed [WW-1:0] tn;
  } cross_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 miss;
    logic                 denz;
    logic [MW-1:0]        den_m;
    logic signed [WW-1:0] sn_f;
    logic signed [WW-1:0] tn_f;
  } fix_t;

  typedef struct packed {
    logic signed [CW-1:0] ox;
    logic signed [CW-1:0] oy;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic                 miss;
    logic                 tsat;
    logic [MW-1:0]        den;
    logic [RW-1:0]        rt;
    logic [TQW-1:0]       tlow;
    logic [TQW-1:0]       tq;
    logic [RW-1:0]        rs;
    logic [SQW-1:0]       slow;
    logic [SQW-1:0]       sq;
  } div_t;

  typedef struct packed {
    logic signed [CW-1:0]  ox;
    logic signed [CW-1:0]  oy;
    logic                  miss;
    logic [TQW-1:0]        traw;
    logic signed [TPW-1:0] tx;
    logic signed [TPW-1:0] ty;
    logic signed [IPW-1:0] ix;
    logic signed [IPW-1:0] iy;
  } post_t;

  // Configuration registers
  logic [63:0] seg_start_q, seg_end_q, normal_start_q, normal_end_q;
  logic [1:0]  kind_q;
  logic        ign_q;

  logic signed [CW-1:0] p1x, p1y, p2x, p2y, n1x, n1y, n2x, n2y;
  logic signed [DW-1:0] sx_q, sy_q, ndx_q, ndy_q;

  logic      en;
  logic      s1_v_q, s2_v_q, s3_v_q, s4_v_q, p1_v_q;
  in_t       s1_q;
  prod_t     s2_q;
  cross_t    s3_q;
  fix_t      s4_q;
  logic      dv_v_q [TQW+1];
  div_t      dv_q   [TQW+1];
  div_t      dv_d   [TQW+1];
  post_t     p1_q;
  div_t      dv_last;
  logic [TQW-1:0] traw;

  logic signed [HW-1:0] hsum_x, hsum_y;
  norm_req_t nrq_q;
  norm_req_t nrq_d;
  norm_rsp_t rsp;

  logic      out_valid_q, skid_valid_q;
  norm_rsp_t out_q, skid_q;

  // Clamp a hit point sum into the coordinate range
  function automatic logic signed [CW-1:0] sat_c(input logic signed [HW-1:0] v);
    logic [HW-CW:0] top;
    logic signed [CW-1:0] r;
    top = v[HW-1:CW-1];
    if ((&top) || !(|top)) r = v[CW-1:0];
    else if (v[HW-1]) r = {1'b1, {(CW-1){1'b0}}};
    else r = {1'b0, {(CW-1){1'b1}}};
    return r;
  endfunction

  // Take register writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_start_q    <= '0;
      seg_end_q      <= '0;
      normal_start_q <= '0;
      normal_end_q   <= '0;
      kind_q         <= KIND_OTHER;
      ign_q          <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SEG_START:     seg_start_q    <= cfg_data_i;
        CFG_SEG_END:       seg_end_q      <= cfg_data_i;
        CFG_NORMAL_START:  normal_start_q <= cfg_data_i;
        CFG_NORMAL_END:    normal_end_q   <= cfg_data_i;
        CFG_SEG_TYPE:      kind_q <= (cfg_data_i[1:0] == KIND_UNUSED) ? KIND_OTHER
                                                                       : cfg_data_i[1:0];
        CFG_IGNORE_SOURCE: ign_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign p1x = $signed(seg_start_q[32 +: CW]);
  assign p1y = $signed(seg_start_q[0 +: CW]);
  assign p2x = $signed(seg_end_q[32 +: CW]);
  assign p2y = $signed(seg_end_q[0 +: CW]);
  assign n1x = $signed(normal_start_q[32 +: CW]);
  assign n1y = $signed(normal_start_q[0 +: CW]);
  assign n2x = $signed(normal_end_q[32 +: CW]);
  assign n2y = $signed(normal_end_q[0 +: CW]);

  // Segment and normal differences, settled long before a ray needs them
  always_ff @(posedge clk_i) begin
    sx_q  <= DW'(p2x) - DW'(p1x);
    sy_q  <= DW'(p2y) - DW'(p1y);
    ndx_q <= DW'(n2x) - DW'(n1x);
    ndy_q <= DW'(n2y) - DW'(n1y);
  end

  // Stall the whole pipeline only while the skid register is occupied
  assign en         = !skid_valid_q;
  assign in_ready_o = en;

  // Advance the valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      for (int k = 0; k <= TQW; k++) dv_v_q[k] <= 1'b0;
      p1_v_q <= 1'b0;
      nrq_q  <= '0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      dv_v_q[0] <= s4_v_q;
      for (int k = 0; k < TQW; k++) dv_v_q[k+1] <= dv_v_q[k];
      p1_v_q <= dv_v_q[TQW];
      nrq_q  <= nrq_d;
    end
  end

  // Capture the ray and the offset from origin to segment start
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q.ox <= $signed(origin_x_i[CW-1:0]);
      s1_q.oy <= $signed(origin_y_i[CW-1:0]);
      s1_q.dx <= $signed(dir_x_i[CW-1:0]);
      s1_q.dy <= $signed(dir_y_i[CW-1:0]);
      s1_q.wx <= DW'(p1x) - DW'($signed(origin_x_i[CW-1:0]));
      s1_q.wy <= DW'(p1y) - DW'($signed(origin_y_i[CW-1:0]));
    end
  end

  // Form all cross and dot product terms
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_q.ox <= s1_q.ox;
      s2_q.oy <= s1_q.oy;
      s2_q.dx <= s1_q.dx;
      s2_q.dy <= s1_q.dy;
      s2_q.pa <= PW'(s1_q.dx) * PW'(sy_q);
      s2_q.pb <= PW'(s1_q.dy) * PW'(sx_q);
      s2_q.pc <= PW'(s1_q.wx) * PW'(s1_q.dy);
      s2_q.pd <= PW'(s1_q.wy) * PW'(s1_q.dx);
      s2_q.pe <= PW'(s1_q.wx) * PW'(sy_q);
      s2_q.pf <= PW'(s1_q.wy) * PW'(sx_q);
      s2_q.pg <= PW'(n1x) * PW'(s1_q.dx);
      s2_q.ph <= PW'(n1y) * PW'(s1_q.dy);
    end
  end

  // Combine terms; drop ignored sources and targets seen from the back
  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q.ox   <= s2_q.ox;
      s3_q.oy   <= s2_q.oy;
      s3_q.dx   <= s2_q.dx;
      s3_q.dy   <= s2_q.dy;
      s3_q.den  <= WW'(s2_q.pa) - WW'(s2_q.pb);
      s3_q.sn   <= WW'(s2_q.pc) - WW'(s2_q.pd);
      s3_q.tn   <= WW'(s2_q.pe) - WW'(s2_q.pf);
      s3_q.miss <= (ign_q && (kind_q == KIND_SOURCE)) ||
                   ((kind_q == KIND_TARGET) && !(WW'(s2_q.pg) + WW'(s2_q.ph) < 0));
    end
  end

  // Make the denominator positive
  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q.ox    <= s3_q.ox;
      s4_q.oy    <= s3_q.oy;
      s4_q.dx    <= s3_q.dx;
      s4_q.dy    <= s3_q.dy;
      s4_q.miss  <= s3_q.miss;
      s4_q.denz  <= (s3_q.den == '0);
      s4_q.den_m <= MW'(s3_q.den[WW-1] ? -s3_q.den : s3_q.den);
      s4_q.sn_f  <= s3_q.den[WW-1] ? -s3_q.sn : s3_q.sn;
      s4_q.tn_f  <= s3_q.den[WW-1] ? -s3_q.tn : s3_q.tn;
    end
  end

  // Range tests, distance saturation and divider load
  always_comb begin
    dv_d[0].ox   = s4_q.ox;
    dv_d[0].oy   = s4_q.oy;
    dv_d[0].dx   = s4_q.dx;
    dv_d[0].dy   = s4_q.dy;
    dv_d[0].miss = s4_q.miss || s4_q.denz || (s4_q.sn_f < 0) || (s4_q.tn_f <= 0) ||
                   (s4_q.sn_f[MW-1:0] > s4_q.den_m);
    dv_d[0].tsat = {{SH{1'b0}}, s4_q.tn_f[MW-1:0]} >= {s4_q.den_m, {SH{1'b0}}};
    dv_d[0].den  = s4_q.den_m;
    dv_d[0].rt   = RW'(s4_q.tn_f[MW-1:SH]);
    dv_d[0].tlow = {s4_q.tn_f[SH-1:0], {FRAC{1'b0}}};
    dv_d[0].tq   = '0;
    dv_d[0].rs   = RW'(s4_q.sn_f[MW-1:1]);
    dv_d[0].slow = {s4_q.sn_f[0], {FRAC{1'b0}}};
    dv_d[0].sq   = '0;
  end

  // Distance and segment position dividers, one quotient bit per stage
  for (genvar k = 0; k < TQW; k++) begin : g_div
    logic [RW-1:0] rt2;
    logic [RW-1:0] rs2;
    always_comb begin
      dv_d[k+1] = dv_q[k];
      rt2 = {dv_q[k].rt[RW-2:0], dv_q[k].tlow[TQW-1]};
      rs2 = {dv_q[k].rs[RW-2:0], dv_q[k].slow[SQW-1]};
      dv_d[k+1].tlow = dv_q[k].tlow << 1;
      if (rt2 >= RW'(dv_q[k].den)) begin
        dv_d[k+1].rt = rt2 - RW'(dv_q[k].den);
        dv_d[k+1].tq = {dv_q[k].tq[TQW-2:0], 1'b1};
      end else begin
        dv_d[k+1].rt = rt2;
        dv_d[k+1].tq = {dv_q[k].tq[TQW-2:0], 1'b0};
      end
      if (k < SQW) begin
        dv_d[k+1].slow = dv_q[k].slow << 1;
        if (rs2 >= RW'(dv_q[k].den)) begin
          dv_d[k+1].rs = rs2 - RW'(dv_q[k].den);
          dv_d[k+1].sq = {dv_q[k].sq[SQW-2:0], 1'b1};
        end else begin
          dv_d[k+1].rs = rs2;
          dv_d[k+1].sq = {dv_q[k].sq[SQW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k <= TQW; k++) dv_q[k] <= dv_d[k];
    end
  end

  // Scale direction by distance and normal difference by position
  assign dv_last = dv_q[TQW];
  assign traw    = dv_last.tsat ? {TQW{1'b1}} : dv_last.tq;

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.ox   <= dv_last.ox;
      p1_q.oy   <= dv_last.oy;
      p1_q.miss <= dv_last.miss;
      p1_q.traw <= traw;
      p1_q.tx   <= TPW'($signed({1'b0, traw})) * TPW'(dv_last.dx);
      p1_q.ty   <= TPW'($signed({1'b0, traw})) * TPW'(dv_last.dy);
      p1_q.ix   <= IPW'($signed({1'b0, dv_last.sq})) * IPW'(ndx_q);
      p1_q.iy   <= IPW'($signed({1'b0, dv_last.sq})) * IPW'(ndy_q);
    end
  end

  // Hit point with saturation, interpolated normal, zeroed fields on a miss
  assign hsum_x = HW'(p1_q.ox) + HW'(p1_q.tx >>> FRAC);
  assign hsum_y = HW'(p1_q.oy) + HW'(p1_q.ty >>> FRAC);

  always_comb begin
    nrq_d = '0;
    nrq_d.valid = p1_v_q;
    nrq_d.nx = n1x + CW'(p1_q.ix >>> FRAC);
    nrq_d.ny = n1y + CW'(p1_q.iy >>> FRAC);
    if (!p1_q.miss) begin
      nrq_d.side.hit      = 1'b1;
      nrq_d.side.distance = p1_q.traw;
      nrq_d.side.hit_x    = OW'(sat_c(hsum_x));
      nrq_d.side.hit_y    = OW'(sat_c(hsum_y));
      nrq_d.side.kind     = kind_q;
    end
  end

  rsi_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .req_i  (nrq_q),
    .rsp_o  (rsp)
  );

  // Output register with a skid stage behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (en) begin
      if (!out_valid_q || out_ready_i) out_valid_q <= rsp.valid;
      else skid_valid_q <= rsp.valid;
    end else if (out_ready_i) begin
      out_valid_q  <= 1'b1;
      skid_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (!out_valid_q || out_ready_i) out_q <= rsp;
      else skid_q <= rsp;
    end else if (out_ready_i) begin
      out_q <= skid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = out_q.side.hit;
  assign distance_o  = out_q.side.distance;
  assign hit_x_o     = out_q.side.hit_x;
  assign hit_y_o     = out_q.side.hit_y;
  assign normal_x_o  = out_q.normal_x;
  assign normal_y_o  = out_q.normal_y;
  assign hit_kind_o  = out_q.side.kind;

endmodule

@@ tb/sv/ray_segment_intersect_2d_check.sv @@
// Result checker for the ray and segment intersection block: predicts and compares every result.
module ray_segment_intersect_2d_check import rsi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [CFG_IW-1:0]  cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [31:0]        origin_x_i,
  input  logic [31:0]        origin_y_i,
  input  logic [31:0]        dir_x_i,
  input  logic [31:0]        dir_y_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               hit_i,
  input  logic [TQW-1:0]     distance_i,
  input  logic [31:0]        hit_x_i,
  input  logic [31:0]        hit_y_i,
  input  logic [31:0]        normal_x_i,
  input  logic [31:0]        normal_y_i,
  input  logic [1:0]         hit_kind_i,
  output int                 errors_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [131:0] wide_t;

  typedef struct {
    logic            hit;
    logic [TQW-1:0]  distance;
    logic [31:0]     hit_x;
    logic [31:0]     hit_y;
    logic [31:0]     normal_x;
    logic [31:0]     normal_y;
    logic [1:0]      kind;
  } ray_result_t;

  ray_result_t hit_q[$];
  logic [63:0] seg_p1, seg_p2, seg_n1, seg_n2;
  logic [1:0]  seg_kind;
  logic        seg_ign;
  int          rays_in, results_out;

  assign pending_o = rays_in - results_out;

  function automatic wide_t sext(logic [31:0] v);
    return wide_t'($signed(v));
  endfunction

  function automatic wide_t root_floor(wide_t v);
    wide_t r, b;
    r = 0;
    b = wide_t'(1) <<< 126;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic wide_t sat32(wide_t v);
    if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
    if (v < -64'sh80000000) return -64'sh80000000;
    return v;
  endfunction

  // Unit component: truncate |c| * 2^16 / len and restore the sign
  function automatic logic [31:0] unit_part(wide_t c, wide_t len);
    wide_t q;
    q = ((c < 0 ? -c : c) <<< FRAC) / len;
    return (c < 0) ? 32'(-q) : 32'(q);
  endfunction

  // Intersect one ray with the configured segment
  function automatic ray_result_t trace_ray(logic [31:0] oxr, logic [31:0] oyr,
                                            logic [31:0] dxr, logic [31:0] dyr);
    ray_result_t res;
    wide_t ox, oy, dx, dy, p1x, p1y, p2x, p2y, n1x, n1y, n2x, n2y;
    wide_t sx, sy, wx, wy, den, sn, tn, traw, sraw, nx, ny, len;
    logic [1:0] kind;
    res = '{default: '0};
    ox = sext(oxr); oy = sext(oyr); dx = sext(dxr); dy = sext(dyr);
    p1x = sext(seg_p1[63:32]); p1y = sext(seg_p1[31:0]);
    p2x = sext(seg_p2[63:32]); p2y = sext(seg_p2[31:0]);
    n1x = sext(seg_n1[63:32]); n1y = sext(seg_n1[31:0]);
    n2x = sext(seg_n2[63:32]); n2y = sext(seg_n2[31:0]);
    kind = (seg_kind == KIND_UNUSED) ? KIND_OTHER : seg_kind;
    if (seg_ign && kind == KIND_SOURCE) return res;
    if (kind == KIND_TARGET && !(n1x * dx + n1y * dy < 0)) return res;
    sx = p2x - p1x; sy = p2y - p1y; wx = p1x - ox; wy = p1y - oy;
    den = dx * sy - dy * sx;
    if (den == 0) return res;
    sn = wx * dy - wy * dx;
    tn = wx * sy - wy * sx;
    if (den < 0) begin
      den = -den; sn = -sn; tn = -tn;
    end
    if (sn < 0 || sn > den || tn <= 0) return res;
    traw = (tn <<< FRAC) / den;
    if (traw > 64'sh7FFFFFFF) traw = 64'sh7FFFFFFF;
    sraw = (sn <<< FRAC) / den;
    nx = n1x + ((sraw * (n2x - n1x)) >>> FRAC);
    ny = n1y + ((sraw * (n2y - n1y)) >>> FRAC);
    len = root_floor(nx * nx + ny * ny);
    res.hit = 1'b1;
    res.distance = TQW'(traw);
    res.hit_x = 32'(sat32(ox + ((traw * dx) >>> FRAC)));
    res.hit_y = 32'(sat32(oy + ((traw * dy) >>> FRAC)));
    if (len != 0) begin
      res.normal_x = unit_part(nx, len);
      res.normal_y = unit_part(ny, len);
    end
    res.kind = kind;
    return res;
  endfunction

  // Track registers, queue predictions, compare results
  always @(posedge clk_i or negedge rst_ni) begin
    ray_result_t want;
    if (!rst_ni) begin
      seg_p1 = '0; seg_p2 = '0; seg_n1 = '0; seg_n2 = '0;
      seg_kind = KIND_OTHER;
      seg_ign = 1'b0;
      hit_q.delete();
      rays_in <= 0;
      results_out <= 0;
      errors_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SEG_START:     seg_p1 = cfg_data_i;
          CFG_SEG_END:       seg_p2 = cfg_data_i;
          CFG_NORMAL_START:  seg_n1 = cfg_data_i;
          CFG_NORMAL_END:    seg_n2 = cfg_data_i;
          CFG_SEG_TYPE:      seg_kind = cfg_data_i[1:0];
          CFG_IGNORE_SOURCE: seg_ign = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        hit_q.push_back(trace_ray(origin_x_i, origin_y_i, dir_x_i, dir_y_i));
        rays_in <= rays_in + 1;
      end
      if (out_valid_i && out_ready_i) begin
        results_out <= results_out + 1;
        if (hit_q.size() == 0) begin
          $error("result with no request pending");
          errors_o <= errors_o + 1;
        end else begin
          want = hit_q.pop_front();
          if (hit_i !== want.hit || distance_i !== want.distance ||
              hit_x_i !== want.hit_x || hit_y_i !== want.hit_y ||
              normal_x_i !== want.normal_x || normal_y_i !== want.normal_y ||
              hit_kind_i !== want.kind) begin
            errors_o <= errors_o + 1;
            if (hit_i !== want.hit)
              $error("hit: expected %0d actual %0d", want.hit, hit_i);
            if (distance_i !== want.distance)
              $error("distance: expected %0h actual %0h", want.distance, distance_i);
            if (hit_x_i !== want.hit_x)
              $error("hit_x: expected %0h actual %0h", want.hit_x, hit_x_i);
            if (hit_y_i !== want.hit_y)
              $error("hit_y: expected %0h actual %0h", want.hit_y, hit_y_i);
            if (normal_x_i !== want.normal_x)
              $error("normal_x: expected %0h actual %0h", want.normal_x, normal_x_i);
            if (normal_y_i !== want.normal_y)
              $error("normal_y: expected %0h actual %0h", want.normal_y, normal_y_i);
            if (hit_kind_i !== want.kind)
              $error("hit_kind: expected %0d actual %0d", want.kind, hit_kind_i);
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/ray_segment_intersect_2d_test.sv @@
// Testbench top: drives rays and segment settings into the intersection block and gives the verdict.
module ray_segment_intersect_2d_test;
  import rsi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE = 65536;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CFG_IW-1:0]  cfg_index = '0;
  logic [63:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [31:0]        origin_x = '0, origin_y = '0, dir_x = '0, dir_y = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               hit;
  logic [TQW-1:0]     distance;
  logic [31:0]        hit_x, hit_y, normal_x, normal_y;
  logic [1:0]         hit_kind;
  int                 errors, pending;
  bit                 no_idle = 1'b0;
  bit                 hold_req = 1'b0;
  longint             p1x, p1y, p2x, p2y;

  always #5 clk = ~clk;

  ray_segment_intersect_2d uut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .origin_x_i(origin_x), .origin_y_i(origin_y), .dir_x_i(dir_x), .dir_y_i(dir_y),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .hit_o(hit), .distance_o(distance), .hit_x_o(hit_x), .hit_y_o(hit_y),
    .normal_x_o(normal_x), .normal_y_o(normal_y), .hit_kind_o(hit_kind)
  );

  ray_segment_intersect_2d_check checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .origin_x_i(origin_x), .origin_y_i(origin_y), .dir_x_i(dir_x), .dir_y_i(dir_y),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .hit_i(hit), .distance_i(distance), .hit_x_i(hit_x), .hit_y_i(hit_y),
    .normal_x_i(normal_x), .normal_y_i(normal_y), .hit_kind_i(hit_kind),
    .errors_o(errors), .pending_o(pending)
  );

  function automatic logic [63:0] xy(longint x, longint y);
    return {x[31:0], y[31:0]};
  endfunction

  // Write one register, hold until the request is taken, then drop the request and idle
  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [63:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Program the whole segment and track its end points for aimed rays
  task automatic set_segment(logic [63:0] a, logic [63:0] b, logic [63:0] na,
                             logic [63:0] nb, logic [1:0] kind, logic ign);
    cfg_write(CFG_SEG_START, a);
    cfg_write(CFG_SEG_END, b);
    cfg_write(CFG_NORMAL_START, na);
    cfg_write(CFG_NORMAL_END, nb);
    cfg_write(CFG_SEG_TYPE, {62'd0, kind});
    cfg_write(CFG_IGNORE_SOURCE, {63'd0, ign});
    p1x = longint'($signed(a[63:32])); p1y = longint'($signed(a[31:0]));
    p2x = longint'($signed(b[63:32])); p2y = longint'($signed(b[31:0]));
  endtask

  // Offer one ray after a random gap and hold until it is taken
  task automatic send_ray(longint ox, longint oy, longint dx, longint dy);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    origin_x <= ox[31:0];
    origin_y <= oy[31:0];
    dir_x <= dx[31:0];
    dir_y <= dy[31:0];
    in_valid <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
  endtask

  // Aim a ray at a random point along the segment, sometimes reversed or noise
  task automatic random_ray();
    longint fr, tx, ty, ox, oy, dx, dy;
    int k, sh;
    if ($urandom_range(0, 9) < 2) begin
      send_ray($urandom, $urandom, $urandom, $urandom);
    end else begin
      fr = $urandom_range(0, 9) == 0 ? longint'($urandom_range(0, 70000)) - 2000
                                     : longint'($urandom_range(0, ONE));
      tx = p1x + (((p2x - p1x) * fr) >>> 16);
      ty = p1y + (((p2y - p1y) * fr) >>> 16);
      k = $urandom_range(2, 30);
      ox = tx + (longint'($signed($urandom)) >>> (31 - k));
      oy = ty + (longint'($signed($urandom)) >>> (31 - k));
      sh = $urandom_range(0, 3);
      dx = (tx - ox) >>> sh;
      dy = (ty - oy) >>> sh;
      if ($urandom_range(0, 9) == 0) begin
        dx = -dx;
        dy = -dy;
      end
      send_ray(ox, oy, dx, dy);
    end
  endtask

  // Wait for every result, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_rays(int count);
    repeat (count) begin
      if ($urandom_range(0, 99) == 0) no_idle = ~no_idle;
      random_ray();
    end
    no_idle = 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off when asked
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  // Run limit
  initial begin
    #20ms;
    $display("FAIL ray_segment_intersect_2d");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset segment is a point: every ray is parallel
    send_ray(0, 0, ONE, 0);
    send_ray(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    drain();

    // Vertical segment at x=10 from y=-5 to y=5, other surface
    set_segment(xy(10 * ONE, -5 * ONE), xy(10 * ONE, 5 * ONE),
                xy(-ONE, 0), xy(-ONE, ONE), KIND_OTHER, 1'b0);
    send_ray(0, 0, ONE, 0);
    send_ray(0, 0, 10 * ONE, -5 * ONE);
    send_ray(0, 0, 10 * ONE, 5 * ONE);
    send_ray(0, 0, 10 * ONE, 5 * ONE + 1);
    send_ray(0, 0, -ONE, 0);
    send_ray(0, 0, 0, 0);
    send_ray(0, 0, 0, ONE);
    send_ray(0, 0, 1, 0);
    send_ray(10 * ONE, 0, ONE, 0);
    send_ray(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000);
    send_ray(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    send_ray(32'h80000000, 0, 32'h7FFFFFFF, 0);
    random_rays(100);
    hold_req = 1'b1;
    random_rays(200);
    drain();

    // Target surface: front face hits, back face misses
    set_segment(xy(10 * ONE, -5 * ONE), xy(10 * ONE, 5 * ONE),
                xy(-ONE, 0), xy(-ONE, 0), KIND_TARGET, 1'b1);
    send_ray(0, 0, ONE, 0);
    send_ray(20 * ONE, 0, -ONE, 0);
    send_ray(0, 0, ONE, 6 * ONE);
    random_rays(250);
    drain();

    // Source surface, ignored then reported
    cfg_write(CFG_SEG_TYPE, {62'd0, KIND_SOURCE});
    send_ray(0, 0, ONE, 0);
    random_rays(60);
    drain();
    cfg_write(CFG_IGNORE_SOURCE, 64'd0);
    send_ray(0, 0, ONE, 0);
    random_rays(200);
    drain();

    // Unused kind code, normals cancel at the middle
    set_segment(xy(-3 * ONE, 4 * ONE), xy(3 * ONE, 4 * ONE),
                xy(ONE, 0), xy(-ONE, 0), KIND_UNUSED, 1'b1);
    send_ray(0, 0, 0, ONE);
    send_ray(0, 0, -3 * ONE, 4 * ONE);
    random_rays(250);
    drain();

    // Extreme segment and normals
    set_segment(64'h80000000_7FFFFFFF, 64'h7FFFFFFF_80000000,
                64'h7FFFFFFF_80000000, 64'h80000000_7FFFFFFF, KIND_OTHER, 1'b0);
    send_ray(0, 0, 1, 1);
    send_ray(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
    random_rays(250);
    drain();

    // Random segments with all-ones and all-zeros data mixed in
    set_segment(64'hFFFFFFFF_FFFFFFFF, 64'h00000000_00000000,
                64'hFFFFFFFF_FFFFFFFF, 64'd0, KIND_TARGET, 1'b0);
    random_rays(100);
    drain();
    repeat (3) begin
      set_segment(xy(longint'($signed($urandom)) >>> $urandom_range(0, 20),
                     longint'($signed($urandom)) >>> $urandom_range(0, 20)),
                  xy(longint'($signed($urandom)) >>> $urandom_range(0, 20),
                     longint'($signed($urandom)) >>> $urandom_range(0, 20)),
                  {$urandom, $urandom}, {$urandom, $urandom},
                  2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
      random_rays(110);
      drain();
    end

    if (errors == 0) begin
      $display("PASS ray_segment_intersect_2d");
    end else begin
      $display("FAIL ray_segment_intersect_2d");
    end
    $finish;
  end

endmodule
